// File: rtl/core/cff_pkg.sv
// ----------------------------------------------------------------------------
// cff_pkg
// Shared types, field widths and codes for the clipped framebuffer fill core.
// ----------------------------------------------------------------------------
`default_nettype none

package cff_pkg;

  // field widths
  localparam int OP_W        = 3;
  localparam int COORD_W     = 16;
  localparam int DIM_W       = 9;
  localparam int BOX_W       = 17;
  localparam int COLOR_W     = 8;
  localparam int PIX_W       = 32;
  localparam int COUNT_W     = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - PIX_W;

  // command codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_PIXEL = 3'd0;
  localparam op_t OP_HSPAN = 3'd1;
  localparam op_t OP_VSPAN = 3'd2;
  localparam op_t OP_RECT  = 3'd3;
  localparam op_t OP_READ  = 3'd4;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_COLOR_RED    = 3'd2;
  localparam cfg_idx_t CFG_COLOR_GREEN  = 3'd3;
  localparam cfg_idx_t CFG_COLOR_BLUE   = 3'd4;
  localparam cfg_idx_t CFG_COLOR_ALPHA  = 3'd5;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_BASE,
    ST_FILL,
    ST_READ,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic clip;
    logic base;
    logic fill;
    logic read;
    logic rdcap;
    logic load_out;
  } cff_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic is_read;
    logic x_last;
    logic y_last;
    logic out_free;
  } cff_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/cff_ram.sv
// ----------------------------------------------------------------------------
// cff_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/cff_ctrl.sv
// ----------------------------------------------------------------------------
// cff_ctrl
// Sequencer: clearing pass, command setup, pixel fill loop, read, hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  cff_pkg::cff_stat_t stat,
  output cff_pkg::cff_cmd_t  cmd
);

  import cff_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        if (stat.empty) begin
          state_nxt = ST_DONE;
        end else if (stat.is_read) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (stat.x_last && stat.y_last) state_nxt = ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_CLIP:   cmd.clip     = 1'b1;
      ST_BASE:   cmd.base     = 1'b1;
      ST_FILL:   cmd.fill     = 1'b1;
      ST_READ:   cmd.read     = 1'b1;
      ST_RDWAIT: cmd.rdcap    = 1'b1;
      ST_DONE:   cmd.load_out = stat.out_free;
      default:   cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/cff_dp.sv
// ----------------------------------------------------------------------------
// cff_dp
// Datapath: config registers, clipping, pixel address walk, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cff_pkg::cff_cmd_t                   cmd,
  output cff_pkg::cff_stat_t                  stat,
  input  logic [cff_pkg::OP_W-1:0]            in_tuser,
  input  logic [cff_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_valid,
  input  logic [cff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cff_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cff_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                ram_we,
  output logic [ADDR_W-1:0]                   ram_addr,
  output logic [cff_pkg::PIX_W-1:0]           ram_wdata,
  input  logic [cff_pkg::PIX_W-1:0]           ram_rdata
);

  import cff_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // configuration registers
  logic [DIM_W-1:0]   frame_width_r;
  logic [DIM_W-1:0]   frame_height_r;
  logic [COLOR_W-1:0] color_red_r;
  logic [COLOR_W-1:0] color_green_r;
  logic [COLOR_W-1:0] color_blue_r;
  logic [COLOR_W-1:0] color_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 9'd256;
      frame_height_r <= 9'd256;
      color_red_r    <= '0;
      color_green_r  <= '0;
      color_blue_r   <= '0;
      color_alpha_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_COLOR_RED:    color_red_r    <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_GREEN:  color_green_r  <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_BLUE:   color_blue_r   <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_ALPHA:  color_alpha_r  <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, limited by the store geometry
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;

  assign eff_w = (32'(frame_width_r) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_r;
  assign eff_h = (32'(frame_height_r) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                          : frame_height_r;

  // command capture
  logic [OP_W-1:0]    op_r;
  logic [COORD_W-1:0] px_r;
  logic [COORD_W-1:0] py_r;
  logic [COORD_W-1:0] a_r;
  logic [COORD_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_tuser;
      px_r <= in_tdata[15:0];
      py_r <= in_tdata[31:16];
      a_r  <= in_tdata[47:32];
      b_r  <= in_tdata[63:48];
    end
  end

  // box bounds per command, ends ordered
  logic [BOX_W-1:0] px17;
  logic [BOX_W-1:0] py17;
  logic [BOX_W-1:0] a17;
  logic [BOX_W-1:0] b17;
  logic [BOX_W-1:0] bx0;
  logic [BOX_W-1:0] bx1;
  logic [BOX_W-1:0] by0;
  logic [BOX_W-1:0] by1;
  logic [BOX_W-1:0] w17;
  logic [BOX_W-1:0] h17;
  logic             bad_op;
  logic             zero_size;
  logic             empty_c;
  logic [DIM_W-1:0] cx1;
  logic [DIM_W-1:0] cy1;

  assign px17 = {1'b0, px_r};
  assign py17 = {1'b0, py_r};
  assign a17  = {1'b0, a_r};
  assign b17  = {1'b0, b_r};
  assign w17  = BOX_W'(eff_w);
  assign h17  = BOX_W'(eff_h);

  always_comb begin
    bx0       = px17;
    bx1       = px17;
    by0       = py17;
    by1       = py17;
    bad_op    = 1'b0;
    zero_size = 1'b0;
    case (op_r) inside
      OP_PIXEL, OP_READ: begin
        bad_op = 1'b0;
      end
      OP_HSPAN: begin
        if (px_r < a_r) begin
          bx1 = a17;
        end else begin
          bx0 = a17;
        end
      end
      OP_VSPAN: begin
        if (py_r < a_r) begin
          by1 = a17;
        end else begin
          by0 = a17;
        end
      end
      OP_RECT: begin
        bx1       = px17 + a17 - 17'd1;
        by1       = py17 + b17 - 17'd1;
        zero_size = (a_r == '0) || (b_r == '0);
      end
      default: begin
        bad_op = 1'b1;
      end
    endcase
  end

  // clip against the frame, no wrap-around
  assign empty_c = bad_op || zero_size || (eff_w == '0) || (eff_h == '0) ||
                   (bx0 >= w17) || (by0 >= h17);
  assign cx1 = (bx1 >= w17) ? (eff_w - 9'd1) : bx1[DIM_W-1:0];
  assign cy1 = (by1 >= h17) ? (eff_h - 9'd1) : by1[DIM_W-1:0];

  logic             empty_r;
  logic [DIM_W-1:0] x0_r;
  logic [DIM_W-1:0] x1_r;
  logic [DIM_W-1:0] y0_r;
  logic [DIM_W-1:0] y1_r;

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      empty_r <= empty_c;
      x0_r    <= bx0[DIM_W-1:0];
      x1_r    <= cx1;
      y0_r    <= by0[DIM_W-1:0];
      y1_r    <= cy1;
    end
  end

  // address walk: row base plus column, one pixel per cycle
  logic [2*DIM_W-1:0] base_prod;
  logic [ADDR_W-1:0]  row_base_r;
  logic [DIM_W-1:0]   x_r;
  logic [DIM_W-1:0]   y_r;

  assign base_prod = (2*DIM_W)'(y0_r) * (2*DIM_W)'(eff_w);

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      row_base_r <= ADDR_W'(base_prod);
      x_r        <= x0_r;
      y_r        <= y0_r;
    end else if (cmd.fill) begin
      if (x_r == x1_r) begin
        x_r        <= x0_r;
        y_r        <= y_r + 9'd1;
        row_base_r <= row_base_r + ADDR_W'(eff_w);
      end else begin
        x_r <= x_r + 9'd1;
      end
    end
  end

  // result accumulation
  logic [COUNT_W-1:0] count_r;
  logic [PIX_W-1:0]   value_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count_r <= '0;
      value_r <= '0;
    end else begin
      if (cmd.fill) count_r <= count_r + 17'd1;
      if (cmd.rdcap) value_r <= ram_rdata;
    end
  end

  // clearing pass counter
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // store port
  assign ram_we    = cmd.clr_en || cmd.fill;
  assign ram_addr  = cmd.clr_en ? clr_addr_r : (row_base_r + ADDR_W'(x_r));
  assign ram_wdata = cmd.clr_en ? '0
                                : {color_alpha_r, color_blue_r, color_green_r, color_red_r};

  // output register, free again once the pending transfer is taken
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, count_r, value_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status
  assign stat.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign stat.empty    = empty_r;
  assign stat.is_read  = (op_r == OP_READ);
  assign stat.x_last   = (x_r == x1_r);
  assign stat.y_last   = (y_r == y1_r);
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// File: rtl/core/clipped_framebuffer_fill_core.sv
// ----------------------------------------------------------------------------
// clipped_framebuffer_fill_core
// RGBA frame store with clipped pixel, span and rectangle fills and readback.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in_*      slave      in_tvalid/in_tready    tuser: op; tdata: draw command
//   out_*     master     out_tvalid/out_tready  tdata: pixel value, pixel count
//   cfg_*     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A draw is accepted, clipped, set up with its row base and then filled up to
// hand-off, the fill set by the single store write port (one pixel per cycle).
// A read passes through a read and a capture state; an empty or clipped-away
// command goes straight to hand-off. After reset a clearing pass writes zero
// to every word, with in_tready low; configuration writes are taken throughout.
// A finished result waits in the output register while the next command is
// accepted; that command stalls only at its own hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_framebuffer_fill_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cff_pkg::IN_TDATA_W-1:0]     in_tdata,   // pos_x, pos_y, arg_a, arg_b
  input  logic [cff_pkg::OP_W-1:0]           in_tuser,   // op
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cff_pkg::OUT_TDATA_W-1:0]    out_tdata,  // pixel_value, pixels_written
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cff_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cff_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cff_cmd_t          cmd;
  cff_stat_t         stat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [PIX_W-1:0]  ram_rdata;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sequencer
  cff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  cff_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  // frame store
  cff_ram #(
    .WIDTH  (PIX_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/cff_checker.sv
// ----------------------------------------------------------------------------
// cff_checker
// Port-level checks on the fill core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cff_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a read never reports written pixels, a draw never reports read data
  a_read_or_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:0] == 32'd0) || (out_tdata[48:32] == 17'd0))
    else $error("result carries both read data and a pixel count");

  // one command in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in work");

  // clearing pass blocks commands right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("command port open during clearing pass");

endmodule

bind clipped_framebuffer_fill_core cff_checker u_cff_checker (.*);

`default_nettype wire
